>>> rtl/core/nbc_pkg.sv
// Package for the bounding-box autocrop block: field widths, reset values,
// register indexes and the payload types used across the files. No dependencies.
package nbc_pkg;

  localparam int DIM_W       = 13;
  localparam int PIX_W       = 32;
  localparam int DEF_MAX_DIM = 4096;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(4096);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(4096);
  localparam logic [PIX_W-1:0] BG_RESET     = 32'hffff_ffff;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_BACKGROUND   = 2'd2
  } reg_idx_t;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [1:0]       index;
    logic [PIX_W-1:0] value;
  } cfg_t;

  typedef struct packed {
    logic [DIM_W-1:0] top_crop;
    logic [DIM_W-1:0] bottom_crop;
    logic [DIM_W-1:0] left_crop;
    logic [DIM_W-1:0] right_crop;
    logic             content_found;
  } result_t;

  // summary of the row as seen through the pixel being processed
  typedef struct packed {
    logic             row_end;
    logic             has_content;
    logic [DIM_W-1:0] first_col;
    logic [DIM_W-1:0] last_col;
  } row_sum_t;

endpackage

>>> rtl/core/nbc_stream_if.sv
// Valid/ready channel carrying one payload item of a chosen type.
// Depends on nothing; payload types come from nbc_pkg at the point of use.
interface nbc_stream_if #(parameter type data_t = logic);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/nbc_row_scan.sv
// Column counter and per-row first/last content tracking.
// Depends on nbc_pkg.
module nbc_row_scan import nbc_pkg::*; #(
  parameter int POS_W = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr,
  input  logic [DIM_W-1:0] clr_w,
  input  logic [DIM_W-1:0] w_eff,
  input  logic             step,
  input  logic             hit,
  output row_sum_t         row_sum
);

  logic [POS_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0] first_r, first_nxt;
  logic [POS_W-1:0] last_r, last_nxt;
  logic             has_r, has_nxt;

  logic [DIM_W-1:0] first_now;
  logic [POS_W-1:0] last_now;
  logic             has_now;
  logic             row_end;

  // fold the current pixel into the row summary
  always_comb begin
    first_now = (hit && !has_r) ? DIM_W'(col_r) : first_r;
    last_now  = hit ? col_r : last_r;
    has_now   = has_r | hit;
    row_end   = !((DIM_W'(col_r) + DIM_W'(1)) < w_eff);
  end

  assign row_sum = '{row_end:     row_end,
                     has_content: has_now,
                     first_col:   first_now,
                     last_col:    DIM_W'(last_now)};

  // advance the column, clear at the end of the row
  always_comb begin
    col_nxt   = col_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    has_nxt   = has_r;
    if (clr) begin
      col_nxt   = '0;
      first_nxt = clr_w;
      last_nxt  = '0;
      has_nxt   = 1'b0;
    end else if (step) begin
      if (row_end) begin
        col_nxt   = '0;
        first_nxt = w_eff;
        last_nxt  = '0;
        has_nxt   = 1'b0;
      end else begin
        col_nxt   = col_r + POS_W'(1);
        first_nxt = first_now;
        last_nxt  = last_now;
        has_nxt   = has_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      first_r <= clr_w;
      last_r  <= '0;
      has_r   <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
      has_r   <= has_nxt;
    end
  end

endmodule

>>> rtl/core/nbc_frame_acc.sv
// Row counter and frame-level crop accumulation; builds the result item.
// Depends on nbc_pkg.
module nbc_frame_acc import nbc_pkg::*; #(
  parameter int POS_W = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr,
  input  logic [DIM_W-1:0] clr_w,
  input  logic [DIM_W-1:0] w_eff,
  input  logic [DIM_W-1:0] h_eff,
  input  logic             step,
  input  row_sum_t         row_sum,
  output logic             frame_end,
  output result_t          result
);

  logic [POS_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] lead_r, lead_upd;
  logic [DIM_W-1:0] trail_r, trail_upd;
  logic [DIM_W-1:0] left_r, left_upd;
  logic [DIM_W-1:0] right_r, right_upd;
  logic             any_r, any_upd;

  logic [DIM_W-1:0] right_gap;

  // fold a finished row into the frame state
  always_comb begin
    right_gap = w_eff - DIM_W'(1) - row_sum.last_col;
    lead_upd  = lead_r;
    trail_upd = trail_r;
    left_upd  = left_r;
    right_upd = right_r;
    any_upd   = any_r;
    if (row_sum.has_content) begin
      any_upd   = 1'b1;
      trail_upd = '0;
      if (row_sum.first_col < left_r) begin
        left_upd = row_sum.first_col;
      end
      if (right_gap < right_r) begin
        right_upd = right_gap;
      end
    end else begin
      if (!any_r) begin
        lead_upd = lead_r + DIM_W'(1);
      end
      trail_upd = trail_r + DIM_W'(1);
    end
    frame_end = row_sum.row_end && !((DIM_W'(row_r) + DIM_W'(1)) < h_eff);
  end

  assign result = '{top_crop:      lead_upd,
                    bottom_crop:   trail_upd,
                    left_crop:     left_upd,
                    right_crop:    right_upd,
                    content_found: any_upd};

  always_comb begin
    row_nxt = row_r;
    if (step && row_sum.row_end) begin
      row_nxt = frame_end ? '0 : row_r + POS_W'(1);
    end
  end

  // hold between rows, take the folded values at each row end, clear them at frame end
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      row_r   <= '0;
      lead_r  <= '0;
      trail_r <= '0;
      left_r  <= clr_w;
      right_r <= clr_w;
      any_r   <= 1'b0;
    end else if (step && row_sum.row_end) begin
      row_r <= row_nxt;
      if (frame_end) begin
        lead_r  <= '0;
        trail_r <= '0;
        left_r  <= w_eff;
        right_r <= w_eff;
        any_r   <= 1'b0;
      end else begin
        lead_r  <= lead_upd;
        trail_r <= trail_upd;
        left_r  <= left_upd;
        right_r <= right_upd;
        any_r   <= any_upd;
      end
    end
  end

endmodule

>>> rtl/core/nonwhite_bounding_box_crop.sv
// Top level of the bounding-box autocrop block: configuration registers,
// input and result registers. Depends on nbc_pkg, nbc_stream_if,
// nbc_row_scan and nbc_frame_acc.

// The block takes one 32-bit pixel per clock in row-major order and reports,
// in the cycle after the last pixel of a frame is processed, how many empty rows
// lie above and below the content and the least empty margin at the left and
// right of the filled rows, plus a flag that any content was seen. A pixel
// passes an input register and is then folded into the row and frame state;
// one pixel is taken every cycle, and the only stall comes when the last pixel
// of a frame reaches the fold while the previous frame's result is still not
// taken. Writing any of the three registers restarts the frame; sizes of zero
// act as one and sizes above MAX_DIM act as MAX_DIM. An empty frame reports
// the frame height top and bottom, the frame width left and right, flag clear.
module nonwhite_bounding_box_crop import nbc_pkg::*; #(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  logic         clk,
  input  logic         rst_n,
  nbc_stream_if.sink   in_ch,
  nbc_stream_if.source out_ch,
  nbc_stream_if.sink   cfg_ch
);

  // largest usable size in the 13-bit size fields
  localparam int MaxClamp = (MAX_DIM > (1 << DIM_W) - 1) ? (1 << DIM_W) - 1 : MAX_DIM;
  localparam int PosW     = (MaxClamp > 1) ? $clog2(MaxClamp) : 1;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MaxClamp)) begin
      r = DIM_W'(MaxClamp);
    end
    return r;
  endfunction

  logic [DIM_W-1:0] w_eff_r, w_eff_nxt;
  logic [DIM_W-1:0] h_eff_r, h_eff_nxt;
  logic [PIX_W-1:0] bg_r, bg_nxt;
  logic             restart;

  logic             in_vld_r;
  pix_t             pix_r;
  logic             out_vld_r;
  result_t          out_data_r;

  row_sum_t         row_sum;
  result_t          result;
  logic             frame_end;
  logic             out_free;
  logic             step;
  logic             cfg_fire;
  cfg_t             cfg_item;

  // decode configuration writes; a listed register restarts the frame
  assign cfg_ch.ready = 1'b1;
  assign cfg_item     = cfg_ch.data;
  assign cfg_fire     = cfg_ch.valid;

  always_comb begin
    w_eff_nxt = w_eff_r;
    h_eff_nxt = h_eff_r;
    bg_nxt    = bg_r;
    restart   = 1'b0;
    if (!rst_n) begin
      w_eff_nxt = clamp_dim(WIDTH_RESET);
      h_eff_nxt = clamp_dim(HEIGHT_RESET);
      bg_nxt    = BG_RESET;
    end else if (cfg_fire) begin
      case (cfg_item.index)
        REG_FRAME_WIDTH: begin
          w_eff_nxt = clamp_dim(cfg_item.value[DIM_W-1:0]);
          restart   = 1'b1;
        end
        REG_FRAME_HEIGHT: begin
          h_eff_nxt = clamp_dim(cfg_item.value[DIM_W-1:0]);
          restart   = 1'b1;
        end
        REG_BACKGROUND: begin
          bg_nxt  = cfg_item.value;
          restart = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    w_eff_r <= w_eff_nxt;
    h_eff_r <= h_eff_nxt;
    bg_r    <= bg_nxt;
  end

  // fold the registered pixel unless it ends a frame with the result slot full
  assign out_free    = !out_vld_r || out_ch.ready;
  assign step        = in_vld_r && (!frame_end || out_free);
  assign in_ch.ready = !in_vld_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      pix_r <= in_ch.data;
    end
  end

  nbc_row_scan #(.POS_W(PosW)) u_row (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (restart),
    .clr_w   (w_eff_nxt),
    .w_eff   (w_eff_r),
    .step    (step),
    .hit     (pix_r != bg_r),
    .row_sum (row_sum)
  );

  nbc_frame_acc #(.POS_W(PosW)) u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (restart),
    .clr_w     (w_eff_nxt),
    .w_eff     (w_eff_r),
    .h_eff     (h_eff_r),
    .step      (step),
    .row_sum   (row_sum),
    .frame_end (frame_end),
    .result    (result)
  );

  // hold the result item until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step && frame_end) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && frame_end) begin
      out_data_r <= result;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
    (step && frame_end) |=> out_vld_r)
    else $error("frame end did not post a result item");

  a_empty_symmetric: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_data_r.content_found) |->
      (out_data_r.top_crop == out_data_r.bottom_crop &&
       out_data_r.left_crop == out_data_r.right_crop))
    else $error("empty frame result is not symmetric");

  a_rows_fit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_data_r.content_found) |->
      ((out_data_r.top_crop + out_data_r.bottom_crop) < h_eff_r))
    else $error("top and bottom crop exceed the frame height");
`endif

endmodule

>>> dv/tb.sv
// Testbench for nonwhite_bounding_box_crop: streams pixel frames and register
// writes with random idle and stall, predicts each crop result and checks it.
// Depends on nbc_pkg, nbc_stream_if and the block's RTL.
module tb;
  import nbc_pkg::*;

  localparam int MAX_DIM         = DEF_MAX_DIM;
  localparam int SETTLE_CYCLES   = 4;
  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int RANDOM_PIXELS   = 1600;
  localparam int OVERSIZE_PIXELS = 300;

  // index with no register behind it
  localparam logic [1:0] REG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  nbc_stream_if #(.data_t(pix_t))    pixel_ch ();
  nbc_stream_if #(.data_t(result_t)) crop_ch ();
  nbc_stream_if #(.data_t(cfg_t))    reg_ch ();

  nonwhite_bounding_box_crop #(.MAX_DIM(MAX_DIM)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (pixel_ch),
    .out_ch (crop_ch),
    .cfg_ch (reg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Crop predictor state
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  pix_t             bg_reg;
  int               col_pos;
  int               row_pos;
  int               row_first;
  int               row_last;
  bit               row_filled;
  int               lead_empty;
  int               trail_empty;
  int               min_left;
  int               min_right;
  bit               frame_filled;
  result_t          crop_expected[$];

  int error_count;
  int pixels_sent;
  int cycle_count = 0;
  int hold_left = 0;
  bit gap_on;
  bit stall_on;

  function automatic int clamp_dim(logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function void clear_row();
    col_pos    = 0;
    row_first  = clamp_dim(width_reg);
    row_last   = 0;
    row_filled = 1'b0;
  endfunction

  function void clear_frame();
    clear_row();
    row_pos      = 0;
    lead_empty   = 0;
    trail_empty  = 0;
    min_left     = clamp_dim(width_reg);
    min_right    = clamp_dim(width_reg);
    frame_filled = 1'b0;
  endfunction

  // Fold one accepted pixel into the row and frame state; queue a crop at frame end
  function void fold_pixel(pix_t px);
    int      w;
    int      h;
    result_t crop;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    if (px != bg_reg) begin
      if (!row_filled) row_first = col_pos;
      row_last   = col_pos;
      row_filled = 1'b1;
    end
    if (col_pos + 1 < w) begin
      col_pos++;
      return;
    end
    if (row_filled) begin
      frame_filled = 1'b1;
      trail_empty  = 0;
      if (row_first < min_left) min_left = row_first;
      if (w - 1 - row_last < min_right) min_right = w - 1 - row_last;
    end else begin
      if (!frame_filled) lead_empty++;
      trail_empty++;
    end
    clear_row();
    if (row_pos + 1 < h) begin
      row_pos++;
      return;
    end
    crop.top_crop      = DIM_W'(lead_empty);
    crop.bottom_crop   = DIM_W'(trail_empty);
    crop.left_crop     = DIM_W'(min_left);
    crop.right_crop    = DIM_W'(min_right);
    crop.content_found = frame_filled;
    crop_expected.push_back(crop);
    clear_frame();
  endfunction

  // Any listed register write restarts the frame; the spare index does nothing
  function void apply_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      REG_FRAME_WIDTH:  width_reg  = val[DIM_W-1:0];
      REG_FRAME_HEIGHT: height_reg = val[DIM_W-1:0];
      REG_BACKGROUND:   bg_reg     = val;
      default:          return;
    endcase
    clear_frame();
  endfunction

  function void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_dim(int common, int rare);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 85) return $urandom_range(1, common);
    return $urandom_range(1, rare);
  endfunction

  // Size value with random bits above the 13-bit field
  function automatic logic [31:0] dim_value(int d);
    logic [31:0] v;
    v = $urandom();
    v[DIM_W-1:0] = DIM_W'(d);
    return v;
  endfunction

  function automatic pix_t content_word();
    case ($urandom_range(0, 3))
      0:       return bg_reg ^ (32'h1 << $urandom_range(0, 31));
      1:       return ~bg_reg;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_pixel(pix_t px);
    int gap;
    @(negedge clk);
    pixel_ch.valid <= 1'b1;
    pixel_ch.data  <= px;
    @(posedge clk);
    while (!pixel_ch.ready) @(posedge clk);
    fold_pixel(px);
    pixels_sent++;
    gap = gap_on ? pick_idle() : 0;
    if (gap > 0) begin
      @(negedge clk);
      pixel_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop valid, wait for every crop result, then let the pipeline empty
  task automatic wait_drained();
    @(negedge clk);
    pixel_ch.valid <= 1'b0;
    while (crop_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    reg_ch.valid <= 1'b1;
    reg_ch.data  <= {idx, val};
    @(posedge clk);
    while (!reg_ch.ready) @(posedge clk);
    apply_reg(idx, val);
    @(negedge clk);
    reg_ch.valid <= 1'b0;
  endtask

  // Width above the maximum acts as the maximum, so a long partial row posts nothing
  task automatic test_largest_frames();
    gap_on = 1'b0;
    write_reg(REG_FRAME_WIDTH, 32'h0000_1fff);
    write_reg(REG_FRAME_HEIGHT, dim_value(1));
    for (int c = 0; c < OVERSIZE_PIXELS; c++) begin
      send_pixel(c % 37 == 0 ? 32'h7fff_ffff : BG_RESET);
    end
    wait_drained();
    gap_on = 1'b1;
  endtask

  // Zero sizes act as one, so every pixel closes a frame
  task automatic test_single_pixel_frames();
    write_reg(REG_FRAME_WIDTH, 32'h0000_0000);
    write_reg(REG_FRAME_HEIGHT, 32'hffff_e000);
    write_reg(REG_BACKGROUND, 32'h0000_0000);
    send_pixel(32'h0000_0000);
    send_pixel(32'hffff_ffff);
    send_pixel(32'h0000_0001);
    send_pixel(32'h8000_0000);
    wait_drained();
  endtask

  // One content pixel in the middle, one bit off the background
  task automatic test_small_frame();
    write_reg(REG_FRAME_WIDTH, 32'habcd_e003);
    write_reg(REG_FRAME_HEIGHT, dim_value(3));
    write_reg(REG_BACKGROUND, 32'ha5a5_5a5a);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        send_pixel((r == 1 && c == 1) ? 32'ha5a5_5a5b : 32'ha5a5_5a5a);
      end
    end
    wait_drained();
  endtask

  // A write in the middle of a frame throws away its content
  task automatic test_restart_on_write();
    write_reg(REG_FRAME_WIDTH, dim_value(2));
    write_reg(REG_FRAME_HEIGHT, dim_value(2));
    repeat (3) send_pixel(32'h5a5a_a5a5);
    wait_drained();
    write_reg(REG_BACKGROUND, 32'ha5a5_5a5a);
    repeat (4) send_pixel(32'ha5a5_5a5a);
    wait_drained();
  endtask

  // A write to the spare index keeps the frame going
  task automatic test_unknown_index();
    send_pixel(32'ha5a5_5a5a);
    send_pixel(32'h0000_0000);
    wait_drained();
    write_reg(REG_SPARE, 32'hffff_ffff);
    repeat (2) send_pixel(32'ha5a5_5a5a);
    wait_drained();
  endtask

  task automatic test_random_frames();
    int   frame_no;
    int   start;
    int   w;
    int   h;
    int   style;
    int   r0;
    int   r1;
    int   c0;
    int   c1;
    int   cut;
    bit   hit;
    pix_t px;
    frame_no = 0;
    start    = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      gap_on   = $urandom_range(0, 4) != 0;
      stall_on = $urandom_range(0, 4) != 0;
      // reconfigure now and then, always from idle
      if (frame_no % 8 == 0) begin
        wait_drained();
        if ($urandom_range(0, 1)) write_reg(REG_FRAME_WIDTH, dim_value(pick_dim(8, 48)));
        if ($urandom_range(0, 1)) write_reg(REG_FRAME_HEIGHT, dim_value(pick_dim(6, 20)));
        case ($urandom_range(0, 3))
          0:       write_reg(REG_BACKGROUND, 32'h0000_0000);
          1:       write_reg(REG_BACKGROUND, 32'hffff_ffff);
          2:       write_reg(REG_BACKGROUND, $urandom());
          default: ;
        endcase
        if ($urandom_range(0, 5) == 0) write_reg(REG_SPARE, $urandom());
      end
      // hold pixels until every crop result is back
      if (frame_no == 20) wait_drained();
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      if ($urandom_range(0, 19) == 0) begin
        // broken frame: stop partway, then restart it or run on past a spare write
        cut = $urandom_range(1, w * h);
        repeat (cut) send_pixel($urandom_range(0, 1) ? content_word() : bg_reg);
        wait_drained();
        if ($urandom_range(0, 1)) write_reg(REG_BACKGROUND, bg_reg);
        else write_reg(REG_SPARE, $urandom());
      end else begin
        style = $urandom_range(0, 4);
        r0 = $urandom_range(0, h - 1);
        r1 = $urandom_range(r0, h - 1);
        c0 = $urandom_range(0, w - 1);
        c1 = $urandom_range(c0, w - 1);
        for (int r = 0; r < h; r++) begin
          for (int c = 0; c < w; c++) begin
            case (style)
              0: hit = 1'b0;
              1: hit = $urandom_range(0, 99) < 8;
              2: hit = r >= r0 && r <= r1 && c >= c0 && c <= c1 && $urandom_range(0, 3) != 0;
              3: hit = $urandom_range(0, 1);
              default: hit = 1'b1;
            endcase
            px = hit ? content_word() : bg_reg;
            send_pixel(px);
          end
        end
      end
      frame_no++;
    end
    stall_on = 1'b1;
    wait_drained();
  endtask

  // Result side: random stalls, some stretches without
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      crop_ch.ready <= 1'b0;
    end else begin
      crop_ch.ready <= 1'b1;
      if (stall_on && $urandom_range(0, 3) == 0) hold_left = pick_idle();
    end
  end

  // Compare each accepted crop result with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst_n && crop_ch.valid && crop_ch.ready) begin
      got = crop_ch.data;
      if (crop_expected.size() == 0) begin
        $error("crop result with none expected: top %0d bottom %0d left %0d right %0d",
               got.top_crop, got.bottom_crop, got.left_crop, got.right_crop);
        error_count++;
      end else begin
        want = crop_expected.pop_front();
        check_field("top_crop", want.top_crop, got.top_crop);
        check_field("bottom_crop", want.bottom_crop, got.bottom_crop);
        check_field("left_crop", want.left_crop, got.left_crop);
        check_field("right_crop", want.right_crop, got.right_crop);
        check_field("content_found", want.content_found, got.content_found);
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("run exceeded %0d cycles", CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    pixel_ch.valid = 1'b0;
    pixel_ch.data  = '0;
    reg_ch.valid   = 1'b0;
    reg_ch.data    = '0;
    crop_ch.ready  = 1'b0;
    gap_on         = 1'b1;
    stall_on       = 1'b1;
    error_count    = 0;
    pixels_sent    = 0;
    width_reg      = WIDTH_RESET;
    height_reg     = HEIGHT_RESET;
    bg_reg         = BG_RESET;
    clear_frame();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_largest_frames();
    test_single_pixel_frames();
    test_small_frame();
    test_restart_on_write();
    test_unknown_index();
    test_random_frames();

    repeat (SETTLE_CYCLES * 4) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
